// ===== rtl/audio_downmix_hann_window_macros.svh =====
// Assertion helpers for the downmix/window block.
`ifndef AUDIO_DOWNMIX_HANN_WINDOW_MACROS_SVH
`define AUDIO_DOWNMIX_HANN_WINDOW_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADHW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("adhw assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ADHW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("adhw assertion failed");

`endif

// ===== rtl/adhw_pkg.sv =====
`default_nettype none

package adhw_pkg;

	localparam int SAMPLE_W    = 24;  // Q4.20 channel sample
	localparam int SUM_W       = 27;  // sum of up to eight samples
	localparam int CC_W        = 4;   // channel_count register
	localparam int MONO_W      = 22;  // Q2.20 result
	localparam int OUT_FRAC    = 20;
	localparam int Q_W         = OUT_FRAC + 1;  // clamped magnitude, up to 2^20
	localparam int DIVN_W      = 24;  // dividend after early clamp test
	localparam int RECIP_SHIFT = 27;
	localparam int RECIP_W     = 28;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam int DEF_FRAME_LEN   = 1024;
	localparam int DEF_WINDOW_BITS = 16;
	localparam int DEF_QUEUE_DEPTH = 4;

	localparam longint unsigned Q30_ONE = 64'd1 << 30;
	localparam longint unsigned PI_Q30  = 64'd3373259426;

	// register decode on the word address bit
	localparam logic REG_CHANNEL_COUNT = 1'b0;

	// zero acts as one, anything above eight as eight
	function automatic logic [CC_W-1:0] eff_channels(input logic [CC_W-1:0] cc);
		logic [CC_W-1:0] r;
		if (cc == '0) r = CC_W'(1);
		else if (cc > CC_W'(8)) r = CC_W'(8);
		else r = cc;
		return r;
	endfunction

	// ceil(2^27 / cc), exact quotient for dividends below 2^24
	function automatic logic [RECIP_W-1:0] recip(input logic [CC_W-1:0] cc);
		logic [RECIP_W-1:0] r;
		unique case (cc)
			CC_W'(1): r = RECIP_W'(134217728);
			CC_W'(2): r = RECIP_W'(67108864);
			CC_W'(3): r = RECIP_W'(44739243);
			CC_W'(4): r = RECIP_W'(33554432);
			CC_W'(5): r = RECIP_W'(26843546);
			CC_W'(6): r = RECIP_W'(22369622);
			CC_W'(7): r = RECIP_W'(19173962);
			default:  r = RECIP_W'(16777216);
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/adhw_if.sv =====
`default_nettype none

interface adhw_in_if import adhw_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic                       frame_start;

	modport source (output valid, sample_in, frame_start, input ready);
	modport sink (input valid, sample_in, frame_start, output ready);
endinterface

interface adhw_out_if import adhw_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [MONO_W-1:0] mono_out;
	logic                     frame_end;

	modport source (output valid, mono_out, frame_end, input ready);
	modport sink (input valid, mono_out, frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/adhw_front.sv =====
`default_nettype none

module adhw_front import adhw_pkg::*; #(
	parameter int FRAME_LEN = DEF_FRAME_LEN,
	parameter int WIN_W     = $clog2(DEF_FRAME_LEN)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [CC_W-1:0]         cc,
	adhw_in_if.sink                      samples,
	input  wire logic                    room,
	output logic                         push,
	output logic signed [SUM_W-1:0]      push_sum,
	output logic [WIN_W-1:0]             push_idx,
	output logic                         push_last
);

	logic signed [SUM_W-1:0] sum_q;
	logic [2:0]              ch_idx_q;
	logic [WIN_W-1:0]        win_q;

	logic                    accept;
	logic signed [SUM_W-1:0] base_sum;
	logic [2:0]              base_ch;
	logic [WIN_W-1:0]        base_win;
	logic [CC_W-1:0]         ch_next;
	logic                    done;

	assign samples.ready = room;
	assign accept        = samples.valid && room;

	always_comb begin
		base_sum  = samples.frame_start ? '0 : sum_q;
		base_ch   = samples.frame_start ? '0 : ch_idx_q;
		base_win  = samples.frame_start ? '0 : win_q;
		ch_next   = {1'b0, base_ch} + CC_W'(1);
		done      = ch_next >= cc;
		push      = accept && done;
		push_sum  = base_sum + SUM_W'(samples.sample_in);
		push_idx  = base_win;
		push_last = base_win == WIN_W'(FRAME_LEN - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			ch_idx_q <= '0;
			win_q    <= '0;
		end else if (accept) begin
			if (done) begin
				sum_q    <= '0;
				ch_idx_q <= '0;
				win_q    <= push_last ? '0 : base_win + WIN_W'(1);
			end else begin
				sum_q    <= push_sum;
				ch_idx_q <= ch_next[2:0];
				win_q    <= base_win;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/adhw_queue.sv =====
`default_nettype none

module adhw_queue import adhw_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  room,
	input  wire logic             pop,
	output logic                  pop_valid,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign room      = cnt_q != CNT_W'(DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_data  = mem_q[rd_q];
	assign do_push   = push && room;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/adhw_coef_rom.sv =====
`default_nettype none

module adhw_coef_rom import adhw_pkg::*; #(
	parameter int FRAME_LEN   = DEF_FRAME_LEN,
	parameter int WINDOW_BITS = DEF_WINDOW_BITS,
	parameter int WIN_W       = $clog2(DEF_FRAME_LEN),
	parameter int COEF_W      = DEF_WINDOW_BITS + 1
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [WIN_W-1:0] addr,
	output logic [COEF_W-1:0]     rdata_q
);

	localparam longint unsigned WIN_M = (FRAME_LEN > 1) ? longint'(FRAME_LEN - 1) : 64'd1;

	typedef logic [COEF_W-1:0] coef_tab_t [FRAME_LEN];

	// sin^2(pi*j/M) in Q30 via Horner Taylor series, rounded to WINDOW_BITS
	function automatic logic [COEF_W-1:0] hann_coef(input longint unsigned i);
		longint unsigned j, x, x2, t, s, sq;
		j = i;
		if (j > WIN_M) j = WIN_M;
		if (2 * j > WIN_M) j = WIN_M - j;
		x  = (PI_Q30 * j) / WIN_M;
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - ((x2 * t) >> 30) / 156;
		t  = Q30_ONE - ((x2 * t) >> 30) / 110;
		t  = Q30_ONE - ((x2 * t) >> 30) / 72;
		t  = Q30_ONE - ((x2 * t) >> 30) / 42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 6;
		s  = (x * t) >> 30;
		sq = (s * s) >> 30;
		if (sq > Q30_ONE) sq = Q30_ONE;
		return COEF_W'((sq + (64'd1 << (29 - WINDOW_BITS))) >> (30 - WINDOW_BITS));
	endfunction

	function automatic coef_tab_t build_tab();
		coef_tab_t tab;
		for (int k = 0; k < FRAME_LEN; k++) begin
			tab[k] = hann_coef(longint'(k));
		end
		return tab;
	endfunction

	localparam coef_tab_t COEF_TAB = build_tab();

	always_ff @(posedge clk) begin
		if (en) begin
			rdata_q <= COEF_TAB[addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/adhw_back.sv =====
`default_nettype none

module adhw_back import adhw_pkg::*; #(
	parameter int FRAME_LEN   = DEF_FRAME_LEN,
	parameter int WINDOW_BITS = DEF_WINDOW_BITS,
	parameter int WIN_W       = $clog2(DEF_FRAME_LEN)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [CC_W-1:0]     cc,
	input  wire logic                q_valid,
	input  wire logic signed [SUM_W-1:0] q_sum,
	input  wire logic [WIN_W-1:0]    q_idx,
	input  wire logic                q_last,
	output logic                     q_pop,
	adhw_out_if.source               mono
);

	localparam int COEF_W = WINDOW_BITS + 1;
	localparam int PROD_W = SUM_W + COEF_W;
	localparam int RND_W  = PROD_W + 1;
	localparam int P_W    = RND_W - WINDOW_BITS;
	localparam int LIM_W  = CC_W + OUT_FRAC + 1;
	localparam int QF_W   = DIVN_W + RECIP_W;

	logic en;

	logic                 v_s1, neg_s1, last_s1;
	logic [SUM_W-1:0]     mag_s1;
	logic [COEF_W-1:0]    coef_s1;
	logic                 v_s2, neg_s2, last_s2;
	logic [PROD_W-1:0]    prod_s2;
	logic                 v_s3, neg_s3, last_s3, sat_s3;
	logic [DIVN_W-1:0]    p_s3;
	logic                 v_s4, neg_s4, last_s4;
	logic [Q_W-1:0]       q_s4;
	logic                 out_valid_q, frame_end_q;
	logic [MONO_W-1:0]    mono_q;

	logic [SUM_W-1:0]     mag;
	logic [RND_W-1:0]     rnd;
	logic [P_W-1:0]       p;
	logic [LIM_W-1:0]     limit;
	logic [QF_W-1:0]      qf;

	// whole pipeline advances when the output slot is free or being taken
	assign en    = !out_valid_q || mono.ready;
	assign q_pop = en && q_valid;

	adhw_coef_rom #(
		.FRAME_LEN   (FRAME_LEN),
		.WINDOW_BITS (WINDOW_BITS),
		.WIN_W       (WIN_W),
		.COEF_W      (COEF_W)
	) u_rom (
		.clk     (clk),
		.en      (en),
		.addr    (q_idx),
		.rdata_q (coef_s1)
	);

	always_comb begin
		mag   = q_sum[SUM_W-1] ? SUM_W'(-q_sum) : SUM_W'(q_sum);
		rnd   = RND_W'(prod_s2) + (RND_W'(cc) << (WINDOW_BITS - 1));
		p     = P_W'(rnd >> WINDOW_BITS);
		limit = (LIM_W'(cc) << OUT_FRAC) + LIM_W'(cc);
		qf    = QF_W'(p_s3) * QF_W'(recip(cc));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= mag;
			neg_s1  <= q_sum[SUM_W-1];
			last_s1 <= q_last;

			prod_s2 <= PROD_W'(mag_s1) * PROD_W'(coef_s1);
			neg_s2  <= neg_s1;
			last_s2 <= last_s1;

			sat_s3  <= P_W'(limit) <= p;
			p_s3    <= p[DIVN_W-1:0];
			neg_s3  <= neg_s2;
			last_s3 <= last_s2;

			q_s4    <= sat_s3 ? Q_W'(1) << OUT_FRAC : qf[RECIP_SHIFT +: Q_W];
			neg_s4  <= neg_s3;
			last_s4 <= last_s3;

			mono_q      <= neg_s4 ? -MONO_W'(q_s4) : MONO_W'(q_s4);
			frame_end_q <= last_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= q_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	assign mono.valid     = out_valid_q;
	assign mono.mono_out  = mono_q;
	assign mono.frame_end = frame_end_q;

endmodule

`default_nettype wire

// ===== rtl/audio_downmix_hann_window.sv =====
// Channel  Dir  Carries                      Handshake
// samples  in   sample_in Q4.20, frame_start valid/ready
// mono     out  mono_out Q2.20, frame_end    valid/ready
// apb      cfg  channel_count at byte 0      psel/penable, pready tied high
//
// One channel sample is taken per cycle, sustained; nothing stalls the input
// except a full group queue. Once a group's last sample is taken, its mono
// result passes through the group queue, ROM read, multiply by the window,
// rounding/clamp test, reciprocal multiply and output register. The group
// queue and the output register let either side stall alone. Reset is
// asynchronous, active low; no clearing pass, the window ROM is constant.
`default_nettype none

module audio_downmix_hann_window import adhw_pkg::*; #(
	parameter int FRAME_LEN   = DEF_FRAME_LEN,
	parameter int WINDOW_BITS = DEF_WINDOW_BITS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	adhw_in_if.sink                    samples,
	adhw_out_if.source                 mono,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	// window position width, at least one bit for the smallest frame
	localparam int WIN_W = (FRAME_LEN > 2) ? $clog2(FRAME_LEN) : 1;
	localparam int ENT_W = SUM_W + WIN_W + 1;

	logic [CC_W-1:0] cc_q;
	logic [CC_W-1:0] cc_eff;

	// front -> queue
	logic                    push, room, push_last;
	logic signed [SUM_W-1:0] push_sum;
	logic [WIN_W-1:0]        push_idx;

	// queue -> back
	logic             pop, pop_valid;
	logic [ENT_W-1:0] pop_data;

	// config: written on the access phase; only the first word decodes
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= CC_W'(1);
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == REG_CHANNEL_COUNT) begin
			cc_q <= pwdata[CC_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_CHANNEL_COUNT) begin
			prdata = APB_DATA_W'(cc_q);
		end
	end

	// channel count clipped to 1..8 once, shared by both halves
	assign cc_eff = eff_channels(cc_q);

	// front: accumulate a channel group, hand finished groups to the queue
	adhw_front #(
		.FRAME_LEN (FRAME_LEN),
		.WIN_W     (WIN_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cc        (cc_eff),
		.samples   (samples),
		.room      (room),
		.push      (push),
		.push_sum  (push_sum),
		.push_idx  (push_idx),
		.push_last (push_last)
	);

	adhw_queue #(
		.WIDTH (ENT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_sum, push_idx, push_last}),
		.room      (room),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data)
	);

	// back: window, average, round, clamp
	adhw_back #(
		.FRAME_LEN   (FRAME_LEN),
		.WINDOW_BITS (WINDOW_BITS),
		.WIN_W       (WIN_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cc      (cc_eff),
		.q_valid (pop_valid),
		.q_sum   (pop_data[ENT_W-1 -: SUM_W]),
		.q_idx   (pop_data[WIN_W:1]),
		.q_last  (pop_data[0]),
		.q_pop   (pop),
		.mono    (mono)
	);

endmodule

`default_nettype wire

// ===== rtl/adhw_checker.sv =====
`default_nettype none
`include "audio_downmix_hann_window_macros.svh"

module adhw_checker import adhw_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [MONO_W-1:0]     mono_out,
	input wire logic                  frame_end,
	input wire logic                  psel,
	input wire logic                  penable,
	input wire logic                  pwrite,
	input wire logic [APB_ADDR_W-1:0] paddr,
	input wire logic [APB_DATA_W-1:0] pwdata,
	input wire logic [APB_DATA_W-1:0] prdata
);

	logic cfg_wr;
	logic cfg_rd;

	assign cfg_wr = psel && penable && pwrite && paddr[2] == REG_CHANNEL_COUNT;
	assign cfg_rd = psel && !pwrite && paddr[2] == REG_CHANNEL_COUNT;

	// stalled result holds
	`ADHW_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(mono_out) && $stable(frame_end))

	// clamp keeps results within plus or minus one
	`ADHW_ASSERT_NOW(a_out_range, clk, arst_n, out_valid, $signed(mono_out) <= $signed(MONO_W'(1 << OUT_FRAC)) && $signed(mono_out) >= -$signed(MONO_W'(1 << OUT_FRAC)))

	// register reads back what was just written
	`ADHW_ASSERT_NEXT(a_cfg_readback, clk, arst_n, cfg_wr, !cfg_rd || prdata[CC_W-1:0] == $past(pwdata[CC_W-1:0]))

	// upper read bits are always zero
	`ADHW_ASSERT_NOW(a_cfg_upper, clk, arst_n, 1'b1, prdata[APB_DATA_W-1:CC_W] == '0)

endmodule

bind audio_downmix_hann_window adhw_checker u_adhw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (mono.valid),
	.out_ready (mono.ready),
	.mono_out  (mono.mono_out),
	.frame_end (mono.frame_end),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

// Testbench for audio_downmix_hann_window.
// Samples go in through the valid/ready sample channel, mono items come back
// on the mono channel. Each accepted sample is run through a local model of
// the downmix and window. That model covers the channel sum, the divide by the
// channel count, the Hann ROM and the rounding and clamping. Any mono item it
// produces is queued, and every item the block emits is checked against the
// head of that queue.
module tb;
	import adhw_pkg::*;

	localparam int FRAME_LEN   = DEF_FRAME_LEN;
	localparam int WIN_BITS    = DEF_WINDOW_BITS;
	localparam int DRAIN_WAIT  = 12;
	localparam int HOLD_CYCLES = 300;   // long receiver stall for the full-queue test
	localparam int STALL_LIMIT = 2000;  // cycles with no item moving

	// register map: one register, index beyond the list is a spare address
	localparam logic [APB_ADDR_W-1:0] CC_ADDR    = APB_ADDR_W'(0);
	localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = APB_ADDR_W'(4);

	// Hann ROM arithmetic, Q30
	localparam longint unsigned HANN_ONE_Q30 = 64'd1 << 30;
	localparam longint unsigned HANN_PI_Q30  = 64'd3373259426;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam int ONE_Q20 = 1 << OUT_FRAC;

	typedef struct {
		logic signed [MONO_W-1:0] mono_out;
		logic                     frame_end;
	} mono_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	adhw_in_if  smp_if();
	adhw_out_if mono_if();

	audio_downmix_hann_window i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp_if),
		.mono    (mono_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// local copy of the block's state
	logic [CC_W-1:0] pred_cc = CC_W'(1);
	longint          group_sum = 0;
	int              group_fill = 0;
	int              window_pos = 0;
	mono_item_t      mono_expect_q[$];

	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_len = 0;     // raised by a test to ask for a receiver stall
	int hold_done = 0;    // stall cycles served by the receiver
	int idle_cycles = 0;

	// Hann weight at a window position, unsigned Q1.WIN_BITS.
	// sin(x) by Horner Taylor series to x^13, all products truncated to Q30.
	function automatic longint unsigned hann_weight(input int pos);
		longint unsigned m, j, x, x2, t, s, sq;
		int unsigned divs[6] = '{156, 110, 72, 42, 20, 6};
		m = FRAME_LEN - 1;
		j = pos;
		if (j > m) j = m;
		if (2 * j > m) j = m - j;  // fold about the center
		x = (HANN_PI_Q30 * j) / m;
		x2 = (x * x) >> 30;
		t = HANN_ONE_Q30;
		for (int k = 0; k < 6; k++)
			t = HANN_ONE_Q30 - ((x2 * t) >> 30) / divs[k];
		s = (x * t) >> 30;
		sq = (s * s) >> 30;
		if (sq > HANN_ONE_Q30) sq = HANN_ONE_Q30;
		return (sq + (64'd1 << (29 - WIN_BITS))) >> (30 - WIN_BITS);
	endfunction

	// Downmix and window one accepted sample; queue a mono item when the
	// channel group completes.
	function automatic void downmix_predict(input logic signed [SAMPLE_W-1:0] s,
			input logic fs);
		int              eff;
		longint unsigned w, mag, den, q;
		bit              neg, last;
		longint          res;
		mono_item_t      item;
		// zero counts as one channel, above eight as eight
		if (pred_cc == '0) eff = 1;
		else if (pred_cc > CC_W'(8)) eff = 8;
		else eff = pred_cc;
		if (fs) begin
			group_sum = 0;
			group_fill = 0;
			window_pos = 0;
		end
		group_sum += s;
		group_fill++;
		if (group_fill < eff) return;
		w = hann_weight(window_pos);
		neg = group_sum < 0;
		mag = longint'(neg ? -group_sum : group_sum) * w;
		den = longint'(eff) << WIN_BITS;
		q = (mag + den / 2) / den;  // round half away from zero on magnitude
		if (q > longint'(ONE_Q20)) q = ONE_Q20;
		res = neg ? -longint'(q) : longint'(q);
		last = window_pos >= FRAME_LEN - 1;
		item.mono_out = res[MONO_W-1:0];
		item.frame_end = last;
		mono_expect_q = {mono_expect_q, item};
		window_pos = last ? 0 : window_pos + 1;
		group_sum = 0;
		group_fill = 0;
	endfunction

	// Sample mix: full random, in-range audio, extremes, and values around
	// +-1.0 so that the clamp is hit near the center of the window.
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = $urandom;
			4, 5, 6: v = int'($urandom_range(2 * ONE_Q20)) - ONE_Q20;
			7: begin
				case ($urandom_range(4))
					0: v = SAMPLE_MAX;
					1: v = SAMPLE_MIN;
					2: v = 0;
					3: v = -1;
					default: v = 1;
				endcase
			end
			default: begin
				v = ONE_Q20 + int'($urandom_range(64)) - 32;
				if ($urandom_range(1)) v = -v;
			end
		endcase
		return v[SAMPLE_W-1:0];
	endfunction

	// Offer one sample; returns at the edge where it is taken.
	task automatic offer_sample(input logic signed [SAMPLE_W-1:0] s, input logic fs);
		while ($urandom_range(99) < send_idle_pct) begin
			smp_if.valid <= 1'b0;
			@(posedge clk);
		end
		smp_if.valid <= 1'b1;
		smp_if.sample_in <= s;
		smp_if.frame_start <= fs;
		do @(posedge clk); while (!smp_if.ready);
		downmix_predict(s, fs);
	endtask

	// Stop sending, let every queued mono item come out, then let the
	// pipeline settle in case a partial group is still in flight.
	task automatic settle_idle();
		smp_if.valid <= 1'b0;
		while (mono_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// APB write, then read the channel count back.
	task automatic cfg_write(input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// written at this edge; the spare address is ignored
		if (addr == CC_ADDR) pred_cc = data[CC_W-1:0];
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= CC_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== APB_DATA_W'(pred_cc)) begin
			$error("prdata: expected %0d, got %0d", pred_cc, prdata);
			mismatch_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_channels(input logic [CC_W-1:0] cc);
		settle_idle();
		// upper data bits are junk, only the low nibble counts
		cfg_write(CC_ADDR, ($urandom & ~APB_DATA_W'(4'hF)) | APB_DATA_W'(cc));
	endtask

	// Full-scale and unit values right after a frame start, at the reset
	// channel count of one.
	task automatic test_extremes();
		offer_sample(SAMPLE_MAX, 1'b1);
		offer_sample(SAMPLE_MIN, 1'b0);
		offer_sample('0, 1'b0);
		offer_sample(-1, 1'b0);
		offer_sample(1, 1'b0);
		offer_sample(ONE_Q20, 1'b0);
		offer_sample(-ONE_Q20, 1'b0);
	endtask

	// Channel count zero acts as one; fifteen acts as eight.
	task automatic test_channel_limits();
		set_channels(CC_W'(0));
		offer_sample(SAMPLE_MAX, 1'b0);
		offer_sample(SAMPLE_MIN, 1'b0);
		set_channels(CC_W'(15));
		repeat (8) offer_sample(SAMPLE_MAX, 1'b0);
	endtask

	// Frame start in the middle of a group drops the partial sum.
	task automatic test_frame_restart();
		set_channels(CC_W'(3));
		offer_sample(SAMPLE_MAX, 1'b0);
		offer_sample(SAMPLE_MAX, 1'b0);
		offer_sample(-ONE_Q20, 1'b1);
		offer_sample(SAMPLE_MIN, 1'b0);
		offer_sample(ONE_Q20, 1'b0);
	endtask

	// Write to an address past the register list must leave the count alone.
	task automatic test_spare_register();
		settle_idle();
		cfg_write(SPARE_ADDR, APB_DATA_W'(2));
		repeat (3) offer_sample(pick_sample(), 1'b0);
	endtask

	// Mostly well-formed frames: starts fall on group boundaries, with the
	// odd start in mid-group.
	task automatic test_random(input int n_items, input logic [CC_W-1:0] cc);
		logic fs;
		set_channels(cc);
		repeat (n_items) begin
			if (group_fill == 0) fs = $urandom_range(99) < 4;
			else fs = $urandom_range(199) == 0;
			offer_sample(pick_sample(), fs);
		end
	endtask

	// Receiver stalls for a long stretch while samples keep coming, so the
	// group queue fills and the input stalls.
	task automatic test_backpressure();
		set_channels(CC_W'(2));
		hold_len <= hold_len + HOLD_CYCLES;
		repeat (80) offer_sample(pick_sample(), 1'b0);
	endtask

	// One channel, one frame start, then past the end of the frame so the
	// window wraps and every position is used, the clamp zone included.
	task automatic test_frame_wrap();
		set_channels(CC_W'(1));
		offer_sample(pick_sample(), 1'b1);
		repeat (FRAME_LEN + 5) offer_sample(pick_sample(), 1'b0);
	endtask

	// receiver: random stalls, plus any long stall a test asks for
	always @(posedge clk) begin
		if (hold_done < hold_len) begin
			mono_if.ready <= 1'b0;
			hold_done <= hold_done + 1;
		end else begin
			mono_if.ready <= $urandom_range(99) >= recv_idle_pct;
		end
	end

	// compare every mono item with the oldest expectation
	always @(posedge clk) begin : check_mono
		mono_item_t want;
		if (arst_n && mono_if.valid && mono_if.ready) begin
			if (mono_expect_q.size() == 0) begin
				$error("unexpected mono item: mono_out %0d, frame_end %0b",
					mono_if.mono_out, mono_if.frame_end);
				mismatch_count++;
			end else begin
				want = mono_expect_q.pop_front();
				if (mono_if.mono_out !== want.mono_out) begin
					$error("mono_out: expected %0d, got %0d", want.mono_out,
						mono_if.mono_out);
					mismatch_count++;
				end
				if (mono_if.frame_end !== want.frame_end) begin
					$error("frame_end: expected %0b, got %0b", want.frame_end,
						mono_if.frame_end);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog: nothing moving for too long ends the run
	always @(posedge clk) begin
		if ((smp_if.valid && smp_if.ready) || (mono_if.valid && mono_if.ready) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		smp_if.valid = 1'b0;
		smp_if.sample_in = '0;
		smp_if.frame_start = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles lightly, receiver heavily
		send_idle_pct = 19;
		recv_idle_pct = 58;
		test_extremes();
		test_channel_limits();
		test_frame_restart();
		test_spare_register();
		test_random(60, CC_W'(5));
		test_random(60, CC_W'(12));

		// and the other way round
		send_idle_pct = 58;
		recv_idle_pct = 19;
		test_random(60, CC_W'(7));
		test_random(60, CC_W'(2));

		// full rate both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_frame_wrap();
		test_random(60, CC_W'(8));
		test_random(60, CC_W'(4));

		settle_idle();
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/adhw_pkg.sv
rtl/adhw_if.sv
rtl/adhw_front.sv
rtl/adhw_queue.sv
rtl/adhw_coef_rom.sv
rtl/adhw_back.sv
rtl/audio_downmix_hann_window.sv
rtl/adhw_checker.sv
sim/tb.sv
